// ===== rtl/mwf_pkg.sv =====
`default_nettype none

package mwf_pkg;

  // action codes of an input item
  localparam logic [1:0] ActLoad    = 2'd0;
  localparam logic [1:0] ActRestart = 2'd1;
  localparam logic [1:0] ActAdvance = 2'd2;

  // walk_status codes
  localparam logic [1:0] StMoved    = 2'd0;
  localparam logic [1:0] StExit     = 2'd1;
  localparam logic [1:0] StBlocked  = 2'd2;
  localparam logic [1:0] StFinished = 2'd3;

  // heading codes
  localparam logic [1:0] DirUp    = 2'd0;
  localparam logic [1:0] DirRight = 2'd1;
  localparam logic [1:0] DirDown  = 2'd2;
  localparam logic [1:0] DirLeft  = 2'd3;

  localparam logic [6:0] SideReset = 7'd8;

  // controller -> datapath
  typedef struct packed {
    logic       mem_wr;     // load item accepted
    logic       restart;    // put walker at origin
    logic       probe;      // read maze at candidate probe_idx
    logic [1:0] probe_idx;  // 0 left, 1 straight, 2 right, 3 back
    logic       commit;     // move walker onto registered candidate
    logic       out_load;   // capture walker cell into output register
  } mwf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;       // registered candidate is in bounds and open
    logic corner;    // registered candidate is the far corner
    logic finished;  // exit already reached
  } mwf_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mwf_datapath.sv =====
`default_nettype none

module mwf_datapath #(
  parameter int MAX_SIDE = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [6:0]        cfg_wdata_i,
  input  wire logic [5:0]        row_i,
  input  wire logic [5:0]        col_i,
  input  wire logic              cell_open_i,
  input  wire mwf_pkg::mwf_cmd_t cmd_i,
  output mwf_pkg::mwf_stat_t     stat_o,
  output logic [5:0]             cell_row_o,
  output logic [5:0]             cell_col_o
);
  import mwf_pkg::*;

  localparam int CoordW = (MAX_SIDE > 64) ? 6 : $clog2(MAX_SIDE);
  localparam int AddrW  = 2 * CoordW;
  localparam int Depth  = 1 << AddrW;
  localparam logic [6:0] SideCap = 7'((MAX_SIDE > 64) ? 64 : MAX_SIDE);
  localparam logic [8:0] StoreSide = 9'(MAX_SIDE);

  logic             maze_mem [Depth];
  logic             rd_q;

  logic [6:0]       side_q;
  logic [5:0]       row_q, col_q;
  logic [1:0]       head_q;
  logic             exit_q;

  logic [5:0]       cand_row_q, cand_col_q;
  logic [1:0]       cand_dir_q;
  logic             cand_inb_q, cand_corner_q;

  logic [5:0]       out_row_q, out_col_q;

  logic [6:0]       side_eff;
  logic [1:0]       dir;
  logic [6:0]       nr, nc;
  logic             neg, inb, corner;
  logic             load_ok;
  logic [AddrW-1:0] wr_addr, rd_addr;

  assign side_eff = (side_q > SideCap) ? SideCap : side_q;
  assign dir      = head_q + 2'd3 + cmd_i.probe_idx;

  always_comb begin
    nr  = {1'b0, row_q};
    nc  = {1'b0, col_q};
    neg = 1'b0;
    case (dir)
      DirUp: begin
        neg = (row_q == 6'd0);
        nr  = {1'b0, row_q} - 7'd1;
      end
      DirRight: nc = {1'b0, col_q} + 7'd1;
      DirDown:  nr = {1'b0, row_q} + 7'd1;
      default: begin
        neg = (col_q == 6'd0);
        nc  = {1'b0, col_q} - 7'd1;
      end
    endcase
  end

  assign inb    = !neg && (nr < side_eff) && (nc < side_eff);
  assign corner = (nr == side_eff - 7'd1) && (nc == side_eff - 7'd1);

  assign load_ok = ({3'b0, row_i} < StoreSide) && ({3'b0, col_i} < StoreSide);
  assign wr_addr = {row_i[CoordW-1:0], col_i[CoordW-1:0]};
  assign rd_addr = {nr[CoordW-1:0], nc[CoordW-1:0]};

  // maze store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr && load_ok) begin
      maze_mem[wr_addr] <= cell_open_i;
    end
    if (cmd_i.probe) begin
      rd_q <= maze_mem[rd_addr];
    end
  end

  // candidate travels alongside the memory read
  always_ff @(posedge clk_i) begin
    if (cmd_i.probe) begin
      cand_row_q    <= nr[5:0];
      cand_col_q    <= nc[5:0];
      cand_dir_q    <= dir;
      cand_corner_q <= corner;
    end
    if (cmd_i.out_load) begin
      out_row_q <= row_q;
      out_col_q <= col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q     <= SideReset;
      row_q      <= '0;
      col_q      <= '0;
      head_q     <= DirDown;
      exit_q     <= 1'b0;
      cand_inb_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        side_q <= cfg_wdata_i;
      end
      if (cmd_i.probe) begin
        cand_inb_q <= inb;
      end
      if (cmd_i.restart) begin
        row_q  <= '0;
        col_q  <= '0;
        head_q <= DirDown;
        exit_q <= 1'b0;
      end else if (cmd_i.commit) begin
        row_q  <= cand_row_q;
        col_q  <= cand_col_q;
        head_q <= cand_dir_q;
        exit_q <= cand_corner_q;
      end
    end
  end

  assign stat_o.hit      = cand_inb_q && rd_q;
  assign stat_o.corner   = cand_corner_q;
  assign stat_o.finished = exit_q;

  assign cell_row_o = out_row_q;
  assign cell_col_o = out_col_q;

endmodule

`default_nettype wire

// ===== rtl/mwf_ctrl.sv =====
`default_nettype none

module mwf_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         action_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              walk_status_o,
  output mwf_pkg::mwf_cmd_t       cmd_o,
  input  wire mwf_pkg::mwf_stat_t stat_i
);
  import mwf_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    EMIT
  } state_e;

  state_e     state_q;
  logic [2:0] idx_q;     // next candidate to read, 4 when all issued
  logic       pend_q;    // a read result is waiting to be checked
  logic [1:0] status_q;
  logic       out_valid_q;
  logic [1:0] walk_status_q;

  logic       accept;
  logic       emit_go;
  logic       all_issued;

  assign accept     = in_valid_i && (state_q == IDLE);
  assign emit_go    = (state_q == EMIT) && (!out_valid_q || out_ready_i);
  assign all_issued = idx_q[2];

  always_comb begin
    cmd_o           = '0;
    cmd_o.probe_idx = idx_q[1:0];
    cmd_o.mem_wr    = accept && (action_i == ActLoad);
    cmd_o.restart   = accept && (action_i == ActRestart);
    cmd_o.out_load  = emit_go;
    if (state_q == SCAN) begin
      cmd_o.commit = pend_q && stat_i.hit;
      cmd_o.probe  = !(pend_q && stat_i.hit) && !all_issued;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= IDLE;
      idx_q         <= '0;
      pend_q        <= 1'b0;
      status_q      <= StMoved;
      out_valid_q   <= 1'b0;
      walk_status_q <= StMoved;
    end else begin
      if (emit_go) begin
        out_valid_q   <= 1'b1;
        walk_status_q <= status_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        IDLE: begin
          if (accept) begin
            idx_q  <= '0;
            pend_q <= 1'b0;
            unique case (action_i)
              ActRestart: begin
                status_q <= StMoved;
                state_q  <= EMIT;
              end
              ActAdvance: begin
                if (stat_i.finished) begin
                  status_q <= StFinished;
                  state_q  <= EMIT;
                end else begin
                  state_q <= SCAN;
                end
              end
              default: state_q <= IDLE;   // load or unused code: no result
            endcase
          end
        end
        SCAN: begin
          if (pend_q && stat_i.hit) begin
            status_q <= stat_i.corner ? StExit : StMoved;
            state_q  <= EMIT;
          end else if (all_issued) begin
            status_q <= StBlocked;
            state_q  <= EMIT;
          end else begin
            idx_q  <= idx_q + 3'd1;
            pend_q <= 1'b1;
          end
        end
        EMIT: begin
          if (emit_go) begin
            state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == IDLE);
  assign out_valid_o   = out_valid_q;
  assign walk_status_o = walk_status_q;

endmodule

`default_nettype wire

// ===== rtl/maze_wall_follower_unit.sv =====
// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+------------------------------------
// config   | in  | cfg_we_i               | cfg_wdata_i (maze side)
// input    | in  | in_valid_i / in_ready_o| action_i, row_i, col_i, cell_open_i
// result   | out | out_valid_o/out_ready_i| cell_row_o, cell_col_o, walk_status_o
//
// An advance reads one neighbour per cycle through the single read port of the maze
// store, each checked in the cycle after its read, in the order left, straight,
// right, back; it stops at the first open one and reports blocked when none is.
// Reset clears the walker and sets side 8; the maze store is not cleared. A waiting
// result holds back only the next result item, and the input stays closed while
// that item waits.
`default_nettype none

module maze_wall_follower_unit #(
  parameter int MAX_SIDE = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] action_i,
  input  wire logic [5:0] row_i,
  input  wire logic [5:0] col_i,
  input  wire logic       cell_open_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [5:0]      cell_row_o,
  output logic [5:0]      cell_col_o,
  output logic [1:0]      walk_status_o
);
  import mwf_pkg::*;

  mwf_cmd_t  cmd;
  mwf_stat_t stat;

  mwf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .walk_status_o (walk_status_o),
    .cmd_o         (cmd),
    .stat_i        (stat)
  );

  mwf_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .cell_open_i (cell_open_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cell_row_o  (cell_row_o),
    .cell_col_o  (cell_col_o)
  );

endmodule

`default_nettype wire

// ===== rtl/mwf_checker.sv =====
`default_nettype none

module mwf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [1:0] action_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [5:0] cell_row_o,
  input wire logic [5:0] cell_col_o,
  input wire logic [1:0] walk_status_o
);
  import mwf_pkg::*;

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(cell_row_o) && $stable(cell_col_o) && $stable(walk_status_o))
    else $error("stalled result changed");

  // the far corner lies on the diagonal
  a_exit_diag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (walk_status_o == StExit) |-> (cell_row_o == cell_col_o))
    else $error("exit reported off the diagonal");

  // an item that gives a result closes the input in the cycle after it is taken
  a_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && ((action_i == ActRestart) || (action_i == ActAdvance))
      |=> !in_ready_o)
    else $error("input reopened while an item is in work");

endmodule

bind maze_wall_follower_unit mwf_checker u_mwf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .action_i      (action_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .cell_row_o    (cell_row_o),
  .cell_col_o    (cell_col_o),
  .walk_status_o (walk_status_o)
);

`default_nettype wire

// ===== bench/maze_wall_follower_unit_test.sv =====
`default_nettype none

module maze_wall_follower_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mwf_pkg::*;

  localparam int StoreSide = 64;
  localparam logic [1:0] ActUnused = 2'd3;
  localparam int SettleCycles = 12;
  localparam int QuietLimit = 4000;
  localparam int PhaseItems = 25;
  localparam int RoomSide = 8;

  typedef struct packed {
    logic [5:0] row;
    logic [5:0] col;
    logic [1:0] status;
  } walk_res_t;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [6:0] side;
    logic [1:0] act;
    logic [5:0] r;
    logic [5:0] c;
    logic       o;
    bit         typed;
    walk_res_t  want;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] action_i = '0;
  logic [5:0] row_i = '0;
  logic [5:0] col_i = '0;
  logic       cell_open_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [5:0] cell_row_o;
  logic [5:0] cell_col_o;
  logic [1:0] walk_status_o;

  // typed expectation travels with the item it belongs to
  logic      typed_i = 1'b0;
  walk_res_t typed_res = '0;

  maze_wall_follower_unit #(
    .MAX_SIDE(StoreSide)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .cell_open_i  (cell_open_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_row_o   (cell_row_o),
    .cell_col_o   (cell_col_o),
    .walk_status_o(walk_status_o)
  );

  always #10 clk_i = ~clk_i;

  // walker shadow state
  bit         maze_bits [0:StoreSide*StoreSide-1];
  bit         written [0:StoreSide*StoreSide-1];
  logic [6:0] side_q = SideReset;
  logic [5:0] w_row = '0;
  logic [5:0] w_col = '0;
  logic [1:0] w_head = DirDown;
  bit         w_done = 1'b0;

  walk_res_t  pos_q[$];
  int         errs = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         sent_count = 0;
  int         cur_eff = 8;
  stim_row_t  dir_tab[$];

  task automatic log_fail(input string msg);
    errs++;
    if (errs <= 10) $display("%s", msg);
  endtask

  task automatic walk_step(input logic [1:0] act, output walk_res_t res);
    int eff;
    int nr;
    int nc;
    int t;
    logic [1:0] d;
    bit found;
    eff = (side_q > 7'd64) ? 64 : int'(side_q);
    found = 1'b0;
    res.status = StBlocked;
    if (act == ActRestart) begin
      w_row = '0;
      w_col = '0;
      w_head = DirDown;
      w_done = 1'b0;
      res.status = StMoved;
    end else if (w_done) begin
      res.status = StFinished;
    end else begin
      // left, straight, right, back relative to heading
      for (t = 0; t < 4; t++) begin
        if (!found) begin
          d = w_head + 2'd3 + 2'(t);
          nr = int'(w_row);
          nc = int'(w_col);
          case (d)
            DirUp:    nr = nr - 1;
            DirRight: nc = nc + 1;
            DirDown:  nr = nr + 1;
            DirLeft:  nc = nc - 1;
          endcase
          if (nr >= 0 && nc >= 0 && nr < eff && nc < eff && maze_bits[nr*StoreSide+nc]) begin
            found = 1'b1;
            w_row = 6'(nr);
            w_col = 6'(nc);
            w_head = d;
            if (nr == eff - 1 && nc == eff - 1) begin
              w_done = 1'b1;
              res.status = StExit;
            end else begin
              res.status = StMoved;
            end
          end
        end
      end
    end
    res.row = w_row;
    res.col = w_col;
  endtask

  // result checking, then prediction of the item taken at this edge
  always @(posedge clk_i) begin
    walk_res_t got;
    walk_res_t want;
    walk_res_t pred;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.row = cell_row_o;
        got.col = cell_col_o;
        got.status = walk_status_o;
        if (pos_q.size() == 0) begin
          log_fail($sformatf("unexpected result: row %0d col %0d status %0d",
                             got.row, got.col, got.status));
        end else begin
          want = pos_q.pop_front();
          if (got.row !== want.row || got.col !== want.col || got.status !== want.status)
            log_fail($sformatf({"mismatch: row exp %0d got %0d, col exp %0d got %0d, ",
                                "status exp %0d got %0d"},
                               want.row, got.row, want.col, got.col,
                               want.status, got.status));
        end
      end
      if (cfg_we_i) side_q = cfg_wdata_i;
      if (in_valid_i && in_ready_o) begin
        if (action_i == ActLoad) begin
          maze_bits[{row_i, col_i}] = cell_open_i;
        end else if (action_i == ActRestart || action_i == ActAdvance) begin
          walk_step(action_i, pred);
          pos_q.push_back(typed_i ? typed_res : pred);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles with no handshake
  int quiet = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet = 0;
    else
      quiet = quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] a, input logic [5:0] r, input logic [5:0] c,
                           input logic o, input bit typed, input walk_res_t want);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    action_i <= a;
    row_i <= r;
    col_i <= c;
    cell_open_i <= o;
    typed_i <= typed;
    typed_res <= want;
    if (a == ActLoad) written[{r, c}] = 1'b1;
    if (a != ActUnused) sent_count++;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // one edge first so that the last item taken is already predicted
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pos_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_side(input logic [6:0] v);
    drain();
    // loads give no result, so allow the last one to settle
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_eff = (v > 7'd64) ? 64 : int'(v);
  endtask

  // load every cell inside the side, or only the ones never loaded; a side wider than
  // the room loads only the corner room and walls it off to keep the walker inside
  task automatic fill_side(input int eff, input int open_pct, input bit all);
    int r;
    int c;
    int span;
    span = (eff > RoomSide) ? RoomSide : eff;
    for (r = 0; r < span; r++)
      for (c = 0; c < span; c++)
        if (all || !written[r*StoreSide+c])
          push_item(ActLoad, 6'(r), 6'(c), ($urandom_range(99) < open_pct), 1'b0, '0);
    if (eff > RoomSide) begin
      for (r = 0; r < RoomSide; r++) begin
        push_item(ActLoad, 6'(r), 6'(RoomSide), 1'b0, 1'b0, '0);
        push_item(ActLoad, 6'(RoomSide), 6'(r), 1'b0, 1'b0, '0);
      end
    end
  endtask

  task automatic add_cfg(input logic [6:0] v);
    stim_row_t row;
    row = '{kind: RowCfg, side: v, act: ActLoad, r: '0, c: '0, o: 1'b0, typed: 1'b0, want: '0};
    dir_tab.push_back(row);
  endtask

  task automatic add_item(input logic [1:0] a, input logic [5:0] r, input logic [5:0] c,
                          input logic o, input bit typed, input logic [5:0] er,
                          input logic [5:0] ec, input logic [1:0] es);
    stim_row_t row;
    row.kind = RowItem;
    row.side = '0;
    row.act = a;
    row.r = r;
    row.c = c;
    row.o = o;
    row.typed = typed;
    row.want.row = er;
    row.want.col = ec;
    row.want.status = es;
    dir_tab.push_back(row);
  endtask

  initial begin
    logic [6:0] phase_sides [10];
    int ph;
    int base;
    int pick;
    int kmax;
    int lim;
    bit paused;
    phase_sides = '{7'd8, 7'd3, 7'd2, 7'd64, 7'd0, 7'd127, 7'd5, 7'd1, 7'd16, 7'd6};
    paused = 1'b0;

    // one-cell maze, empty maze, then a two-by-two maze
    add_cfg(7'd1);
    add_item(ActRestart, 6'd63, 6'd63, 1'b1, 1'b1, 6'd0, 6'd0, StMoved);
    add_item(ActAdvance, 6'd0, 6'd0, 1'b0, 1'b1, 6'd0, 6'd0, StBlocked);
    add_item(ActUnused, 6'd63, 6'd0, 1'b0, 1'b0, '0, '0, StMoved);
    add_cfg(7'd0);
    add_item(ActAdvance, 6'd63, 6'd63, 1'b1, 1'b1, 6'd0, 6'd0, StBlocked);
    add_cfg(7'd2);
    add_item(ActLoad, 6'd0, 6'd0, 1'b1, 1'b0, '0, '0, StMoved);
    add_item(ActLoad, 6'd0, 6'd1, 1'b0, 1'b0, '0, '0, StMoved);
    add_item(ActLoad, 6'd1, 6'd0, 1'b0, 1'b0, '0, '0, StMoved);
    add_item(ActLoad, 6'd1, 6'd1, 1'b1, 1'b0, '0, '0, StMoved);
    add_item(ActLoad, 6'd63, 6'd63, 1'b1, 1'b0, '0, '0, StMoved);
    add_item(ActRestart, 6'd0, 6'd0, 1'b0, 1'b0, '0, '0, StMoved);
    // both neighbours walled
    add_item(ActAdvance, 6'd0, 6'd0, 1'b0, 1'b1, 6'd0, 6'd0, StBlocked);
    add_item(ActLoad, 6'd0, 6'd1, 1'b1, 1'b0, '0, '0, StMoved);
    add_item(ActAdvance, 6'd21, 6'd42, 1'b1, 1'b0, '0, '0, StMoved);
    add_item(ActAdvance, 6'd42, 6'd21, 1'b0, 1'b0, '0, '0, StMoved);
    add_item(ActAdvance, 6'd0, 6'd0, 1'b0, 1'b1, 6'd1, 6'd1, StFinished);
    add_item(ActRestart, 6'd63, 6'd63, 1'b1, 1'b0, '0, '0, StMoved);
    add_item(ActAdvance, 6'd0, 6'd0, 1'b0, 1'b0, '0, '0, StMoved);
    // shrink under the walker: still steps back to the origin
    add_cfg(7'd1);
    add_item(ActAdvance, 6'd0, 6'd0, 1'b0, 1'b0, '0, '0, StMoved);
    add_item(ActLoad, 6'd0, 6'd63, 1'b0, 1'b0, '0, '0, StMoved);
    add_item(ActLoad, 6'd63, 6'd0, 1'b1, 1'b0, '0, '0, StMoved);
    add_item(ActUnused, 6'd63, 6'd63, 1'b1, 1'b0, '0, '0, StMoved);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 29;
    stall_pct = 29;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == RowCfg)
        write_side(dir_tab[i].side);
      else
        push_item(dir_tab[i].act, dir_tab[i].r, dir_tab[i].c, dir_tab[i].o,
                  dir_tab[i].typed, dir_tab[i].want);
    end

    for (ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 49; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 49; end
        default: begin gap_pct = 29; stall_pct = 29; end
      endcase
      write_side(phase_sides[ph]);
      fill_side(cur_eff, 65, 1'b0);
      base = sent_count;
      while (sent_count - base < PhaseItems) begin
        if (ph == 1 && !paused && sent_count - base >= 20) begin
          drain();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 55) begin
          // restart and walk
          push_item(ActRestart, 6'($urandom_range(63)), 6'($urandom_range(63)),
                    1'($urandom_range(1)), 1'b0, '0);
          kmax = 3 * cur_eff + 6;
          if (kmax > 40) kmax = 40;
          repeat ($urandom_range(kmax, 1))
            push_item(ActAdvance, 6'($urandom_range(63)), 6'($urandom_range(63)),
                      1'($urandom_range(1)), 1'b0, '0);
        end else if (pick < 63 && cur_eff <= RoomSide) begin
          // fresh maze; a fully open one always leads to the corner
          fill_side(cur_eff, ($urandom_range(1) != 0) ? 100 : 60, 1'b1);
        end else if (pick < 78) begin
          // a wide side keeps its loads inside the room
          lim = (cur_eff > RoomSide) ? RoomSide - 1 : 63;
          push_item(ActLoad, 6'($urandom_range(lim)), 6'($urandom_range(lim)),
                    1'($urandom_range(1)), 1'b0, '0);
        end else if (pick < 86) begin
          push_item(ActUnused, 6'($urandom_range(63)), 6'($urandom_range(63)),
                    1'($urandom_range(1)), 1'b0, '0);
        end else begin
          push_item(ActAdvance, 6'($urandom_range(63)), 6'($urandom_range(63)),
                    1'($urandom_range(1)), 1'b0, '0);
        end
      end
    end

    drain();
    repeat (SettleCycles * 2) @(posedge clk_i);
    if (errs == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
